// File: rtl/dm2d_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dm2d_pkg
// Types, constants and the square-root step shared by the 2D distance block.
// ----------------------------------------------------------------------------
package dm2d_pkg;

  localparam int COORD_WIDTH_DEF = 16;

  localparam int DIST_W      = 17;
  localparam int OUT_TDATA_W = ((DIST_W + 7) / 8) * 8;
  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  localparam int SQ_W        = 2 * DIST_W;        // one squared difference
  localparam int RAD_W       = 2 * (DIST_W + 1);  // radicand, padded to even
  localparam int ROOT_W      = RAD_W / 2;
  localparam int REM_W       = ROOT_W + 1;
  localparam int TRIAL_W     = REM_W + 2;
  localparam int SQRT_STEPS  = 2;                 // root bits per stage
  localparam int SQRT_STAGES = ROOT_W / SQRT_STEPS;

  typedef enum logic [1:0] {
    MODE_EUCLID    = 2'd0,
    MODE_MANHATTAN = 2'd1,
    MODE_CHEBYSHEV = 2'd2,
    MODE_INVALID   = 2'd3
  } mode_t;

  // State of one item inside the root pipeline
  typedef struct packed {
    logic [RAD_W-1:0]  rad;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
    logic [DIST_W-1:0] fast;    // result of the non-root metrics
    logic              euclid;  // take the root as result
    logic              bad;
  } sq_t;

  // One digit-by-digit step: one root bit from two radicand bits
  function automatic sq_t sqrt_step(sq_t s);
    sq_t                o;
    logic [TRIAL_W-1:0] rs;
    logic [TRIAL_W-1:0] t;
    o     = s;
    rs    = {s.rem, s.rad[RAD_W-1 -: 2]};
    t     = {1'b0, s.root, 2'b01};
    o.rad = {s.rad[RAD_W-3:0], 2'b00};
    if (rs >= t) begin
      o.rem  = REM_W'(rs - t);
      o.root = {s.root[ROOT_W-2:0], 1'b1};
    end else begin
      o.rem  = rs[REM_W-1:0];
      o.root = {s.root[ROOT_W-2:0], 1'b0};
    end
    return o;
  endfunction

endpackage

// File: rtl/distance_metric_2d.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// distance_metric_2d
// Euclidean, Manhattan or Chebyshev distance between two signed 2D points.
// ----------------------------------------------------------------------------
// One point pair is taken per clock while the output side is not stalled. The
// depth is set by the 18-bit integer square root, resolved two root bits per
// stage over nine stages, behind three stages for the differences, the squares
// and their sum, and ahead of the output register.
// Each stage holds while the one after it is full and stalled, so bubbles
// close up and the input keeps taking transfers while a result waits, until
// every stage is full.
// Coordinates are two's complement with 4 fraction bits; the distance is
// unsigned with 4 fraction bits and saturates at 131071. Selector value 3
// gives distance 0 with bad_mode set.
// ----------------------------------------------------------------------------
module distance_metric_2d #(
  parameter int COORD_WIDTH = dm2d_pkg::COORD_WIDTH_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     in_tvalid,
  output logic                                     in_tready,
  // p_x, p_y, q_x, q_y, zero padded to bytes
  input  logic [((4*COORD_WIDTH+7)/8)*8-1:0]       in_tdata,
  // mode
  input  logic [1:0]                               in_tuser,
  output logic                                     out_tvalid,
  input  logic                                     out_tready,
  // distance, zero padded to bytes
  output logic [dm2d_pkg::OUT_TDATA_W-1:0]         out_tdata,
  // bad_mode
  output logic                                     out_tuser
);
  import dm2d_pkg::*;

  localparam int CW  = COORD_WIDTH;
  localparam int EW  = (CW > DIST_W) ? CW : DIST_W;
  localparam int NST = SQRT_STAGES + 4;
  localparam int OST = NST - 1;

  // stage handshake
  logic [NST-1:0] vld_r;
  logic [NST-1:0] rdy;

  always_comb begin
    rdy[OST] = !vld_r[OST] || out_tready;
    for (int k = OST - 1; k >= 0; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (rdy[0]) begin
        vld_r[0] <= in_tvalid;
      end
      for (int k = 1; k < NST; k++) begin
        if (rdy[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  assign in_tready = rdy[0];

  // stage 1: absolute differences
  logic [CW-1:0] px, py, qx, qy;
  logic [CW:0]   ddx, ddy;
  logic [CW-1:0] dx_nxt, dy_nxt;
  logic [CW-1:0] dx_r, dy_r;
  mode_t         mode_r;

  assign px  = in_tdata[CW-1:0];
  assign py  = in_tdata[2*CW-1:CW];
  assign qx  = in_tdata[3*CW-1:2*CW];
  assign qy  = in_tdata[4*CW-1:3*CW];
  assign ddx = {qx[CW-1], qx} - {px[CW-1], px};
  assign ddy = {qy[CW-1], qy} - {py[CW-1], py};

  always_comb begin
    dx_nxt = ddx[CW] ? CW'(-ddx) : ddx[CW-1:0];
    dy_nxt = ddy[CW] ? CW'(-ddy) : ddy[CW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      dx_r   <= dx_nxt;
      dy_r   <= dy_nxt;
      mode_r <= mode_t'(in_tuser);
    end
  end

  // stage 2: squares, saturation, Manhattan and Chebyshev
  logic [EW-1:0]     dxe, dye, big;
  logic              sat;
  logic [DIST_W-1:0] dxc, dyc;
  logic [DIST_W:0]   man;
  logic [SQ_W-1:0]   sqx_nxt, sqy_nxt;
  logic [DIST_W-1:0] fast_nxt;
  logic              euclid_nxt, bad_nxt;
  logic [SQ_W-1:0]   sqx_r, sqy_r;
  logic [DIST_W-1:0] fast_r;
  logic              euclid_r, bad_r;

  always_comb begin
    dxe        = EW'(dx_r);
    dye        = EW'(dy_r);
    big        = (dxe > dye) ? dxe : dye;
    sat        = big > EW'(DIST_MAX);
    dxc        = dxe[DIST_W-1:0];
    dyc        = dye[DIST_W-1:0];
    man        = {1'b0, dxc} + {1'b0, dyc};
    sqx_nxt    = dxc * dxc;
    sqy_nxt    = dyc * dyc;
    bad_nxt    = 1'b0;
    euclid_nxt = 1'b0;
    fast_nxt   = '0;
    unique case (mode_r)
      MODE_EUCLID: begin
        euclid_nxt = !sat;
        fast_nxt   = sat ? DIST_MAX : '0;
      end
      MODE_MANHATTAN: begin
        fast_nxt = (sat || man[DIST_W]) ? DIST_MAX : man[DIST_W-1:0];
      end
      MODE_CHEBYSHEV: begin
        fast_nxt = sat ? DIST_MAX : big[DIST_W-1:0];
      end
      MODE_INVALID: begin
        bad_nxt = 1'b1;
      end
      default: begin
        bad_nxt = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      sqx_r    <= sqx_nxt;
      sqy_r    <= sqy_nxt;
      fast_r   <= fast_nxt;
      euclid_r <= euclid_nxt;
      bad_r    <= bad_nxt;
    end
  end

  // stage 3 (sq_r[0]): sum of squares; then root stages sq_r[1..]
  sq_t sq_r   [SQRT_STAGES+1];
  sq_t sq_nxt [SQRT_STAGES+1];

  always_comb begin
    sq_nxt[0].rad    = RAD_W'({1'b0, sqx_r} + {1'b0, sqy_r});
    sq_nxt[0].rem    = '0;
    sq_nxt[0].root   = '0;
    sq_nxt[0].fast   = fast_r;
    sq_nxt[0].euclid = euclid_r;
    sq_nxt[0].bad    = bad_r;
  end

  for (genvar j = 1; j <= SQRT_STAGES; j++) begin : g_root
    always_comb begin
      sq_nxt[j] = sq_r[j-1];
      for (int s = 0; s < SQRT_STEPS; s++) begin
        sq_nxt[j] = sqrt_step(sq_nxt[j]);
      end
    end
  end

  for (genvar j = 0; j <= SQRT_STAGES; j++) begin : g_sq_reg
    always_ff @(posedge clk) begin
      if (rdy[2+j]) begin
        sq_r[j] <= sq_nxt[j];
      end
    end
  end

  // output register
  sq_t               fin;
  logic [DIST_W-1:0] dist_nxt;
  logic [DIST_W-1:0] dist_r;
  logic              bad_out_r;

  always_comb begin
    fin = sq_r[SQRT_STAGES];
    if (fin.euclid) begin
      dist_nxt = (fin.root > ROOT_W'(DIST_MAX)) ? DIST_MAX : fin.root[DIST_W-1:0];
    end else begin
      dist_nxt = fin.fast;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[OST]) begin
      dist_r    <= dist_nxt;
      bad_out_r <= fin.bad;
    end
  end

  assign out_tvalid = vld_r[OST];
  assign out_tdata  = OUT_TDATA_W'(dist_r);
  assign out_tuser  = bad_out_r;

endmodule
